// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: command codes, cell constants and control types for the text console writer.
// No dependencies; imported by tcw_cursor and text_console_writer.
package tcw_pkg;

    // command codes on the input word
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // cursor update request from the top level sequencer
    typedef struct packed {
        logic home;
        logic put;
        logic newline;
    } t_cur_req;

endpackage

// ===== rtl/tcw_cursor.sv =====
// tcw_cursor: cursor row, column and linear position with wrap and scroll detection.
// Depends on tcw_pkg (t_cur_req).
module tcw_cursor #(
    parameter int ROWS = 25,
    parameter int COLS = 80,
    parameter int AW   = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_cur_req i_req,
    output logic [AW-1:0]     o_pos,
    output logic              o_scroll
);
    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLS);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_pos, n_pos;
    logic          row_step;

    assign row_step = i_req.put & (i_req.newline | (r_col == LAST_COL));
    assign o_scroll = row_step & (r_row == LAST_ROW);
    assign o_pos    = r_pos;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_pos = r_pos;
        if (i_req.home) begin
            n_row = '0;
            n_col = '0;
            n_pos = '0;
        end else if (row_step) begin
            n_col = '0;
            if (o_scroll) begin
                // stay on the last row, back at its first cell
                n_pos = LAST_BASE;
            end else begin
                n_row = r_row + 1'b1;
                n_pos = AW'({1'b0, r_pos} + (AW+1)'(COLS) - (AW+1)'(r_col));
            end
        end else if (i_req.put) begin
            n_col = r_col + 1'b1;
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_pos <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// text_console_writer: character-cell screen store with put, read and clear commands.
// Depends on tcw_pkg and tcw_cursor; the screen store is an on-chip memory in this file.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_cmd, i_char_code, i_cell_index
//  out     | output    | o_out_valid/i_out_stall | o_cursor_position, o_cell_char,
//          |           |                       | o_cell_attr, o_scrolled
//  cfg     | input     | i_cfg_we              | i_cfg_data (text attribute)
//
// Put without scroll, read and unused commands pass from accept through the done step to
// the result register. Clear blanks every cell, and a scrolling put copies each row up one
// and blanks the last row; for both the address counter sweeps the single memory port pair one cell per cycle.
// After reset a clearing pass over every cell blanks the store; input stalls meanwhile.
// A new word is taken only when the sequencer is idle and the result register is free or
// being taken in the same cycle.
module text_console_writer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_position,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    output logic        o_scrolled
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW:0]   END_RD    = (AW+1)'(CELLS);
    localparam logic [31:0]   CELLS_W   = 32'(CELLS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_FILL,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_addr;
    logic [AW:0]   r_raddr;
    logic          r_rd_pend;
    logic [7:0]    r_attr;
    logic          r_is_read;
    logic          r_rd_ok;
    logic          r_scr;
    logic          r_out_valid;
    logic [10:0]   r_out_pos;
    logic [7:0]    r_out_char;
    logic [7:0]    r_out_attr;
    logic          r_out_scr;

    logic [15:0]   mem [CELLS];
    logic [15:0]   r_rdata;

    logic          in_acc;
    logic          out_acc;
    logic [31:0]   idx32;
    logic [31:0]   pos32;
    logic          in_range;
    t_cur_req      cur_req;
    logic [AW-1:0] cur_pos;
    logic          cur_scroll;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    assign o_in_stall  = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = r_out_valid & ~i_out_stall;
    assign idx32       = 32'(i_cell_index);
    assign pos32       = 32'(cur_pos);
    assign in_range    = idx32 < CELLS_W;

    assign cur_req.home    = in_acc & (i_cmd == CMD_CLEAR);
    assign cur_req.put     = in_acc & (i_cmd == CMD_PUT);
    assign cur_req.newline = i_char_code == NEWLINE_CODE;

    tcw_cursor #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (cur_req),
        .o_pos    (cur_pos),
        .o_scroll (cur_scroll)
    );

    // write port select: reset pass, blank fill, row copy or character put
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_attr, BLANK_CHAR};
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
            end
            S_FILL: begin
                mem_we = 1'b1;
            end
            S_COPY: begin
                mem_we    = r_rd_pend;
                mem_wdata = r_rdata;
            end
            S_IDLE: begin
                mem_we    = cur_req.put & ~cur_req.newline;
                mem_waddr = cur_pos;
                mem_wdata = {r_attr, i_char_code};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = (r_state == S_COPY) ? r_raddr[AW-1:0] : idx32[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_raddr     <= '0;
            r_rd_pend   <= 1'b0;
            r_attr      <= RESET_ATTR;
            r_is_read   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_CELL) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_read <= i_cmd == CMD_READ;
                        r_rd_ok   <= in_range;
                        r_scr     <= 1'b0;
                        r_addr    <= '0;
                        r_raddr   <= (AW+1)'(COLS);
                        r_rd_pend <= 1'b0;
                        if (cur_req.put && cur_scroll) begin
                            r_scr   <= 1'b1;
                            r_state <= S_COPY;
                        end else if (i_cmd == CMD_CLEAR) begin
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_COPY: begin
                    // read one row ahead, write the word read in the previous cycle
                    if (r_raddr < END_RD) begin
                        r_raddr   <= r_raddr + 1'b1;
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rd_pend <= 1'b0;
                    end
                    if (r_rd_pend) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if ((r_raddr == END_RD) && !r_rd_pend) begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_CELL) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_pos   <= pos32[10:0];
                    r_out_char  <= (r_is_read && r_rd_ok) ? r_rdata[7:0]  : 8'd0;
                    r_out_attr  <= (r_is_read && r_rd_ok) ? r_rdata[15:8] : 8'd0;
                    r_out_scr   <= r_scr;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_char       = r_out_char;
    assign o_cell_attr       = r_out_attr;
    assign o_scrolled        = r_out_scr;

    // a put that runs off the last row must start the row copy
    a_scroll_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_PUT) && cur_scroll) |=> (r_state == S_COPY))
        else $error("scrolling put did not start row copy");

    // a result only appears out of the done step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done step");

    // copy write address trails the read address by one row plus the read latency
    a_copy_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && r_rd_pend) |->
            (r_raddr == ({1'b0, r_addr} + (AW+1)'(COLS + 1))))
        else $error("row copy addresses out of step");

endmodule

// ===== tb/tb_text_console_writer.sv =====
`timescale 1ns / 100ps
// tb_text_console_writer: self-checking bench for the text console writer.
// Uses tcw_pkg and the text_console_writer RTL only; a built-in screen model predicts results.
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int CELLS = ROWS * COLS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned STUCK_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned PHASE_WORDS = 210;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  code;
        logic [10:0] cidx;
    } t_console_word;

    typedef struct packed {
        logic [10:0] pos;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic        scrolled;
    } t_console_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_cmd = '0;
    logic [7:0]  in_char = '0;
    logic [10:0] in_cell = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [10:0] out_pos;
    logic [7:0]  out_char;
    logic [7:0]  out_attr;
    logic        out_scrolled;

    // screen model
    logic [15:0] screen_model [0:CELLS-1];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [7:0]  attr_model;

    t_console_word   pending_q [$];
    t_console_result expected_q [$];

    int unsigned cycle_count = 0;
    int unsigned last_in_cycle = 0;
    int unsigned last_out_cycle = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned error_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    text_console_writer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_cmd             (in_cmd),
        .i_char_code       (in_char),
        .i_cell_index      (in_cell),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_cursor_position (out_pos),
        .o_cell_char       (out_char),
        .o_cell_attr       (out_attr),
        .o_scrolled        (out_scrolled)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void blank_screen(logic [7:0] attr);
        for (int i = 0; i < CELLS; i++) begin
            screen_model[i] = {attr, BLANK_CHAR};
        end
    endfunction

    // Update the screen model with one command and return the result it should give.
    function automatic t_console_result apply_command(t_console_word w);
        t_console_result r;
        int unsigned pos;
        r = '0;
        case (w.cmd)
            CMD_PUT: begin
                if (w.code == NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    pos = cur_row * COLS + cur_col;
                    if (pos < CELLS) begin
                        screen_model[pos] = {attr_model, w.code};
                    end
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    // shift every row up by one and blank the bottom row
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        screen_model[i] = screen_model[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++) begin
                        screen_model[i] = {attr_model, BLANK_CHAR};
                    end
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            CMD_READ: begin
                if (w.cidx < CELLS) begin
                    r.ch = screen_model[w.cidx][7:0];
                    r.attr = screen_model[w.cidx][15:8];
                end
            end
            CMD_CLEAR: begin
                blank_screen(attr_model);
                cur_row = 0;
                cur_col = 0;
            end
            default: begin
            end
        endcase
        pos = cur_row * COLS + cur_col;
        r.pos = pos[10:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Sender: hold a stalled word, otherwise advance to the next pending word after the gap.
    always @(posedge i_clk) begin : sender
        t_console_word next_word;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid) begin
                expected_q.push_back(apply_command({in_cmd, in_char, in_cell}));
                last_in_cycle <= cycle_count;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                next_word = pending_q.pop_front();
                in_cmd <= next_word.cmd;
                in_char <= next_word.code;
                in_cell <= next_word.cidx;
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin : receiver
        int unsigned gap_len;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            gap_len = pick_gap();
            if (gap_len != 0) begin
                out_stall <= 1'b1;
                stall_left <= gap_len - 1;
            end else begin
                stall_left <= $urandom_range(0, 7);
            end
        end
    end

    task automatic flag_error(string what, t_console_result want, t_console_result got);
        error_count++;
        if (error_count <= 10) begin
            $display("%s: expected pos %0d char %02h attr %02h scrolled %0d,",
                     what, want.pos, want.ch, want.attr, want.scrolled);
            $display("    got pos %0d char %02h attr %02h scrolled %0d",
                     got.pos, got.ch, got.attr, got.scrolled);
        end
    endtask

    // Monitor: compare each taken result word against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_console_result got;
        t_console_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            last_out_cycle <= cycle_count;
            got = {out_pos, out_char, out_attr, out_scrolled};
            if (expected_q.size() == 0) begin
                flag_error("result with nothing outstanding", '0, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    flag_error("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    initial begin : watchdog
        do begin
            @(negedge i_clk);
        end while (cycle_count -
                   (last_in_cycle > last_out_cycle ? last_in_cycle : last_out_cycle)
                   < STUCK_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic queue_word(logic [1:0] cmd, logic [7:0] code, logic [10:0] cidx);
        pending_q.push_back('{cmd: cmd, code: code, cidx: cidx});
    endtask

    task automatic queue_put(logic [7:0] code);
        queue_word(CMD_PUT, code, 11'($urandom_range(0, 2047)));
    endtask

    task automatic queue_read();
        logic [10:0] cidx;
        if ($urandom_range(0, 99) < 88) begin
            cidx = 11'($urandom_range(0, CELLS - 1));
        end else begin
            cidx = 11'($urandom_range(CELLS, 2047));
        end
        queue_word(CMD_READ, 8'($urandom_range(0, 255)), cidx);
    endtask

    task automatic queue_traffic(int unsigned count);
        int unsigned queued;
        int unsigned kind;
        int unsigned len;
        queued = 0;
        while (queued < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // a line of text; a few run past the last column and wrap
                len = $urandom_range(0, 99);
                if (len < 70) begin
                    len = $urandom_range(0, 40);
                end else if (len < 90) begin
                    len = $urandom_range(41, COLS - 1);
                end else begin
                    len = $urandom_range(COLS, 170);
                end
                for (int k = 0; k < len; k++) begin
                    queue_put(8'($urandom_range(0, 255)));
                end
                queued += len;
                if ($urandom_range(0, 9) < 8) begin
                    queue_put(NEWLINE_CODE);
                    queued++;
                end
            end else if (kind < 75) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    queue_read();
                end
                queued += len;
            end else if (kind < 79) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    queue_put(NEWLINE_CODE);
                end
                queued += len;
            end else if (kind < 81) begin
                queue_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                queued++;
            end else if (kind < 84) begin
                queue_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                queued++;
            end else begin
                // noise: any command with any fields
                queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           11'($urandom_range(0, 2047)));
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        attr_model = value;
    endtask

    initial begin : stimulus
        logic [7:0] phase_attr [0:4];
        attr_model = RESET_ATTR;
        blank_screen(RESET_ATTR);
        cur_row = 0;
        cur_col = 0;
        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        for (int p = 2; p < 5; p++) begin
            phase_attr[p] = 8'($urandom_range(0, 255));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, index extremes, odd bytes, unused command, clear
        queue_word(CMD_READ, 8'h00, 11'd0);
        queue_word(CMD_READ, 8'hFF, 11'(CELLS - 1));
        queue_word(CMD_READ, 8'h00, 11'(CELLS));
        queue_word(CMD_READ, 8'hFF, 11'h7FF);
        queue_word(CMD_PUT, 8'h00, 11'h7FF);
        queue_word(CMD_PUT, 8'hFF, 11'd0);
        queue_word(CMD_PUT, 8'h0D, 11'd0);
        queue_word(CMD_PUT, NEWLINE_CODE, 11'd0);
        queue_word(CMD_PUT, 8'h41, 11'd0);
        queue_word(CMD_READ, 8'h00, 11'd0);
        queue_word(CMD_READ, 8'h00, 11'd1);
        queue_word(CMD_READ, 8'h00, 11'd2);
        queue_word(CMD_READ, 8'h00, 11'(COLS));
        queue_word(CMD_UNUSED, 8'hFF, 11'h7FF);
        queue_word(CMD_CLEAR, 8'h00, 11'd0);
        queue_word(CMD_READ, 8'h00, 11'd1);
        queue_word(CMD_PUT, 8'h7E, 11'd0);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            write_attribute(phase_attr[p]);
            no_idle = (p == 3);
            queue_traffic(PHASE_WORDS);
            // block the result side for a long stretch while words keep coming
            if (p == 1) begin
                hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
